FILE: rtl/core/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Types and constants shared by the wav pcm16 stream parser modules.
// ----------------------------------------------------------------------------
package wps_pkg;

  // one byte of the file
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic               item_kind;
    logic signed [15:0] pcm_sample;
    logic [2:0]         parse_status;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_total;
    logic               final_item;
  } out_word_t;

  // results pushed by the parser for one byte, sample before status
  typedef struct packed {
    logic sample_v;
    logic status_v;
  } wps_push_t;

  typedef enum logic [2:0] {
    PH_TAGS = 3'd0,
    PH_HEAD = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_NO_RIFF    = 3'd2,
    ST_NO_WAVE    = 3'd3,
    ST_BAD_FORMAT = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
  localparam logic [31:0] RIFF_LAST_IDX  = 32'd3;
  localparam logic [31:0] WAVE_LAST_IDX  = 32'd11;
  localparam logic [31:0] HEAD_BYTES     = 32'd8;
  localparam logic [31:0] HEAD_ID_LEFT   = 32'd4;

  // fmt body offsets of the last byte of each field
  localparam logic [31:0] FMT_FORMAT_END   = 32'd1;
  localparam logic [31:0] FMT_CHANNELS_END = 32'd3;
  localparam logic [31:0] FMT_RATE_END     = 32'd7;
  localparam logic [31:0] FMT_DEPTH_END    = 32'd15;

  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] PCM_DEPTH  = 16'd16;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  localparam logic [RQ_CNT_W-1:0] RQ_FULL        = RQ_CNT_W'(RQ_DEPTH);
  // room for the byte in the stage and the byte being taken, two words each
  localparam logic [RQ_CNT_W-1:0] RQ_STALL_LEVEL = RQ_CNT_W'(RQ_DEPTH - 4);

endpackage

FILE: rtl/core/wps_parser.sv
// ----------------------------------------------------------------------------
// wps_parser
// Chunk walker and sample extractor: one byte per cycle, up to two words out.
// ----------------------------------------------------------------------------
module wps_parser
  import wps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_v,
  input  in_word_t  byte_word,
  output wps_push_t push,
  output out_word_t sample_word,
  output out_word_t status_word
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        riff_r, riff_nxt;
  logic        wave_r, wave_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] channels_r, channels_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] data_left_r, data_left_nxt;
  logic [16:0] frame_off_r, frame_off_nxt;
  logic        frame_ok_r, frame_ok_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [7:0]  b;
  logic [31:0] left_dec;
  logic [31:0] fmt_pos;
  logic [31:0] data_dec;
  logic [16:0] frame_bytes;
  logic [17:0] off_inc;
  logic        fmt_ok_r;
  logic        fmt_ok_nxt;
  status_t     status_code;

  assign b           = byte_word.file_byte;
  assign left_dec    = left_r - 32'd1;
  assign fmt_pos     = len_r - left_r;
  assign data_dec    = data_left_r - 32'd1;
  assign frame_bytes = {channels_r, 1'b0};
  assign off_inc     = {1'b0, frame_off_r} + 18'd1;
  assign fmt_ok_r    = (format_r == FORMAT_PCM) && (depth_r == PCM_DEPTH) &&
                       (channels_r != 16'd0);

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    tag_nxt       = tag_r;
    riff_nxt      = riff_r;
    wave_nxt      = wave_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    format_nxt    = format_r;
    channels_nxt  = channels_r;
    rate_nxt      = rate_r;
    depth_nxt     = depth_r;
    data_left_nxt = data_left_r;
    frame_off_nxt = frame_off_r;
    frame_ok_nxt  = frame_ok_r;
    held_nxt      = held_r;
    push          = '0;
    fmt_ok_nxt    = 1'b0;
    status_code   = ST_OK;

    sample_word               = '0;
    sample_word.item_kind     = KIND_SAMPLE;
    sample_word.pcm_sample    = {b, held_r};
    sample_word.rate_hz       = rate_r;
    sample_word.channel_total = channels_r;
    status_word               = '0;

    if (byte_v) begin
      if (pos_r != '1) begin
        pos_nxt = pos_r + 32'd1;
      end

      case (phase_r)
        PH_TAGS: begin
          tag_nxt = {tag_r[23:0], b};
          if (pos_r == RIFF_LAST_IDX) begin
            riff_nxt = (tag_nxt == TAG_RIFF);
            if (tag_nxt != TAG_RIFF) begin
              phase_nxt = PH_DONE;
            end
          end else if (pos_r == WAVE_LAST_IDX) begin
            wave_nxt = (tag_nxt == TAG_WAVE);
            if (tag_nxt == TAG_WAVE) begin
              phase_nxt = PH_HEAD;
              left_nxt  = HEAD_BYTES;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_HEAD: begin
          // id big-endian into the tag shifter, length little-endian
          if (left_r > HEAD_ID_LEFT) begin
            tag_nxt = {tag_r[23:0], b};
          end else begin
            len_nxt = {b, len_r[31:8]};
          end
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            if (tag_nxt == TAG_DATA) begin
              data_left_nxt = len_nxt;
              frame_off_nxt = '0;
              phase_nxt     = (len_nxt == 32'd0) ? PH_DONE : PH_DATA;
            end else begin
              phase_nxt = (tag_nxt == TAG_FMT) ? PH_FMT : PH_SKIP;
              left_nxt  = len_nxt;
              if (len_nxt == 32'd0) begin
                phase_nxt = PH_HEAD;
                left_nxt  = HEAD_BYTES;
              end
            end
          end
        end
        PH_FMT: begin
          tag_nxt = {b, tag_r[31:8]};
          if (fmt_pos == FMT_FORMAT_END) begin
            format_nxt = tag_nxt[31:16];
          end else if (fmt_pos == FMT_CHANNELS_END) begin
            channels_nxt = tag_nxt[31:16];
          end else if (fmt_pos == FMT_RATE_END) begin
            rate_nxt = tag_nxt;
          end else if (fmt_pos == FMT_DEPTH_END) begin
            depth_nxt = tag_nxt[31:16];
          end
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_HEAD;
            left_nxt  = HEAD_BYTES;
          end
        end
        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_HEAD;
            left_nxt  = HEAD_BYTES;
          end
        end
        PH_DATA: begin
          if (fmt_ok_r) begin
            if (frame_off_r == 17'd0) begin
              frame_ok_nxt = (data_left_r >= {15'd0, frame_bytes});
              held_nxt     = b;
            end else if (frame_off_r == 17'd1 && frame_ok_r) begin
              push.sample_v = 1'b1;
            end
            frame_off_nxt = (off_inc >= {1'b0, frame_bytes}) ? 17'd0 : off_inc[16:0];
          end
          data_left_nxt = data_dec;
          if (data_dec == 32'd0) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (byte_word.end_of_file) begin
        fmt_ok_nxt = (format_nxt == FORMAT_PCM) && (depth_nxt == PCM_DEPTH) &&
                     (channels_nxt != 16'd0);
        if (pos_nxt < MIN_FILE_BYTES) begin
          status_code = ST_SHORT;
        end else if (!riff_nxt) begin
          status_code = ST_NO_RIFF;
        end else if (!wave_nxt) begin
          status_code = ST_NO_WAVE;
        end else if (!fmt_ok_nxt) begin
          status_code = ST_BAD_FORMAT;
        end else if (phase_nxt == PH_DATA && data_left_nxt != 32'd0) begin
          status_code = ST_TRUNCATED;
        end else begin
          status_code = ST_OK;
        end
        push.status_v             = 1'b1;
        status_word.item_kind     = KIND_STATUS;
        status_word.parse_status  = status_code;
        status_word.rate_hz       = rate_nxt;
        status_word.channel_total = channels_nxt;
        status_word.final_item    = 1'b1;

        // back to the reset state for the next file
        phase_nxt     = PH_TAGS;
        pos_nxt       = '0;
        tag_nxt       = '0;
        riff_nxt      = 1'b0;
        wave_nxt      = 1'b0;
        len_nxt       = '0;
        left_nxt      = '0;
        format_nxt    = '0;
        channels_nxt  = '0;
        rate_nxt      = '0;
        depth_nxt     = '0;
        data_left_nxt = '0;
        frame_off_nxt = '0;
        frame_ok_nxt  = 1'b0;
        held_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAGS;
      pos_r       <= '0;
      tag_r       <= '0;
      riff_r      <= 1'b0;
      wave_r      <= 1'b0;
      len_r       <= '0;
      left_r      <= '0;
      format_r    <= '0;
      channels_r  <= '0;
      rate_r      <= '0;
      depth_r     <= '0;
      data_left_r <= '0;
      frame_off_r <= '0;
      frame_ok_r  <= 1'b0;
      held_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      tag_r       <= tag_nxt;
      riff_r      <= riff_nxt;
      wave_r      <= wave_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      format_r    <= format_nxt;
      channels_r  <= channels_nxt;
      rate_r      <= rate_nxt;
      depth_r     <= depth_nxt;
      data_left_r <= data_left_nxt;
      frame_off_r <= frame_off_nxt;
      frame_ok_r  <= frame_ok_nxt;
      held_r      <= held_nxt;
    end
  end

  a_sample_in_data : assert property (@(posedge clk) disable iff (!rst_n)
    push.sample_v |-> (phase_r == PH_DATA && fmt_ok_r))
    else $error("sample word outside a valid data chunk");

  a_final_resets : assert property (@(posedge clk) disable iff (!rst_n)
    push.status_v |=> (phase_r == PH_TAGS && pos_r == 32'd0))
    else $error("parser did not restart after the final byte");

endmodule

FILE: rtl/core/wps_result_fifo.sv
// ----------------------------------------------------------------------------
// wps_result_fifo
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module wps_result_fifo
  import wps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  wps_push_t           push,
  input  out_word_t           sample_word,
  input  out_word_t           status_word,
  input  logic                pop,
  output logic                head_v,
  output out_word_t           head_word,
  output logic [RQ_CNT_W-1:0] count
);

  out_word_t           mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] count_r, count_nxt;
  logic [RQ_PTR_W-1:0] status_slot;
  logic [RQ_CNT_W-1:0] push_cnt;

  // status lands after the sample when both come from one byte
  assign status_slot = push.sample_v ? wr_ptr_r + RQ_PTR_W'(1) : wr_ptr_r;
  assign push_cnt    = RQ_CNT_W'(push.sample_v) + RQ_CNT_W'(push.status_v);
  assign wr_ptr_nxt  = wr_ptr_r + push_cnt[RQ_PTR_W-1:0];
  assign rd_ptr_nxt  = rd_ptr_r + RQ_PTR_W'(pop);
  assign count_nxt   = count_r + push_cnt - RQ_CNT_W'(pop);

  assign head_v    = (count_r != '0);
  assign head_word = mem[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push.sample_v) begin
      mem[wr_ptr_r] <= sample_word;
    end
    if (push.status_v) begin
      mem[status_slot] <= status_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RQ_FULL)
    else $error("result queue overflow");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push_cnt == '0) |=> (count_r == '0))
    else $error("result queue count moved while empty and idle");

endmodule

FILE: rtl/core/wav_pcm16_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser
// WAV byte stream parser: checks tags, walks chunks, emits first-channel
// pcm16 samples and a status word on the last byte of the file.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall   | in_word_t: file_byte, end_of_file
//  out_    | output    | out_valid/out_stall | out_word_t: sample or final status
//
//  one byte per cycle sustained while in_stall is low; a byte reaches the parser in the
//  cycle after it is taken and its words can leave the queue the cycle after that
//  the final byte can yield two words (sample then status), both queued at once
//  in_stall rises while the result queue holds more than RQ_DEPTH - 4 words
//  rst_n is synchronous; the parser also returns to reset after each final byte
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser
  import wps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic                stage_v_r, stage_v_nxt;
  in_word_t            stage_word_r;
  wps_push_t           push;
  out_word_t           sample_word;
  out_word_t           status_word;
  logic [RQ_CNT_W-1:0] q_count;
  logic                in_take;
  logic                out_take;

  assign in_stall    = (q_count > RQ_STALL_LEVEL);
  assign in_take     = in_valid && !in_stall;
  assign out_take    = out_valid && !out_stall;
  assign stage_v_nxt = in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_word_r <= in_data;
    end
  end

  wps_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_v      (stage_v_r),
    .byte_word   (stage_word_r),
    .push        (push),
    .sample_word (sample_word),
    .status_word (status_word)
  );

  wps_result_fifo u_result_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .sample_word (sample_word),
    .status_word (status_word),
    .pop         (out_take),
    .head_v      (out_valid),
    .head_word   (out_data),
    .count       (q_count)
  );

  a_status_needs_eof : assert property (@(posedge clk) disable iff (!rst_n)
    push.status_v |-> (stage_v_r && stage_word_r.end_of_file))
    else $error("status word without a final byte");

endmodule
